FILE: sv/ucp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ucp_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned KindW  = 2;
   localparam int unsigned CodeW  = 11;
   localparam int unsigned LeadW  = 5;
   localparam int unsigned RevCnt = 61;

   localparam logic [KindW-1:0] KIND_CHAR     = 2'd0;
   localparam logic [KindW-1:0] KIND_END_OK   = 2'd1;
   localparam logic [KindW-1:0] KIND_END_FAIL = 2'd2;

   // what the front hands to the back
   typedef enum logic [1:0] {
      OP_CHAR,
      OP_PAIR,
      OP_FAIL,
      OP_END
   } op_type;

   // data holds the ascii byte, the 11-bit code point, or the open-lead flag for end
   typedef struct packed {
      op_type           op;
      logic [CodeW-1:0] data;
   } entry_type;

   typedef struct packed {
      logic             hit;
      logic [ByteW-1:0] code;
   } map_type;

   localparam logic [15:0] CyrLo    = 16'h0410;
   localparam logic [15:0] CyrHi    = 16'h044F;
   localparam logic [15:0] CyrOfs   = 16'h0350;
   localparam logic [15:0] LatLo    = 16'h0080;
   localparam logic [15:0] LatHi    = 16'h00FF;
   localparam logic [15:0] DjeLo    = 16'h0402;
   localparam logic [15:0] DjeHi    = 16'h0403;
   localparam logic [15:0] DjeOfs   = 16'h0382;

   localparam logic [15:0] RevCode [RevCnt] = '{
      16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020,
      16'h2021, 16'h20AC, 16'h2030, 16'h0409, 16'h2039,
      16'h040A, 16'h040C, 16'h040B, 16'h040F, 16'h0452,
      16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022,
      16'h2013, 16'h2014, 16'h2122, 16'h0459, 16'h203A,
      16'h045A, 16'h045C, 16'h045B, 16'h045F, 16'h00A0,
      16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490,
      16'h00A6, 16'h00A7, 16'h0401, 16'h00A9, 16'h0404,
      16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
      16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491,
      16'h00B5, 16'h00B6, 16'h00B7, 16'h0451, 16'h2116,
      16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455,
      16'h0457
   };

   localparam logic [ByteW-1:0] RevByte [RevCnt] = '{
      8'h82, 8'h83, 8'h84, 8'h85, 8'h86,
      8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B,
      8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90,
      8'h91, 8'h92, 8'h93, 8'h94, 8'h95,
      8'h96, 8'h97, 8'h99, 8'h9A, 8'h9B,
      8'h9C, 8'h9D, 8'h9E, 8'h9F, 8'hA0,
      8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'hA5,
      8'hA6, 8'hA7, 8'hA8, 8'hA9, 8'hAA,
      8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF,
      8'hB0, 8'hB1, 8'hB2, 8'hB3, 8'hB4,
      8'hB5, 8'hB6, 8'hB7, 8'hB8, 8'hB9,
      8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'hBE,
      8'hBF
   };

   function automatic map_type map_code(input logic [CodeW-1:0] cp);
      logic [15:0] cpw;
      logic [15:0] diff;
      map_type     res;
      cpw = {{(16-CodeW){1'b0}}, cp};
      res = '0;
      if (cpw >= CyrLo && cpw <= CyrHi) begin
         diff = cpw - CyrOfs;
         res.hit  = 1'b1;
         res.code = diff[ByteW-1:0];
      end else if (cpw >= LatLo && cpw <= LatHi) begin
         res.hit  = 1'b1;
         res.code = cpw[ByteW-1:0];
      end else if (cpw >= DjeLo && cpw <= DjeHi) begin
         diff = cpw - DjeOfs;
         res.hit  = 1'b1;
         res.code = diff[ByteW-1:0];
      end else begin
         // table codes are distinct, so an or over all matches is safe
         for (int k = 0; k < RevCnt; k++) begin
            if (RevCode[k] == cpw) begin
               res.hit  = 1'b1;
               res.code = res.code | RevByte[k];
            end
         end
      end
      return res;
   endfunction

endpackage
`default_nettype wire

FILE: sv/ucp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ucp_front (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire  [ucp_pkg::ByteW-1:0]   req_in_byte,
   input  wire                         q_full,
   output logic                        q_push,
   output ucp_pkg::entry_type          q_entry
);
   import ucp_pkg::*;

   logic             lead_pending_ff, lead_pending_in;
   logic [LeadW-1:0] lead_bits_ff, lead_bits_in;
   logic             accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      lead_pending_in = lead_pending_ff;
      lead_bits_in    = lead_bits_ff;
      q_push          = 1'b0;
      q_entry.op      = OP_CHAR;
      q_entry.data    = {{(CodeW-ByteW){1'b0}}, req_in_byte};
      if (accept) begin
         priority if (req_in_byte == '0) begin
            q_push          = 1'b1;
            q_entry.op      = OP_END;
            q_entry.data    = {{(CodeW-1){1'b0}}, lead_pending_ff};
            lead_pending_in = 1'b0;
            lead_bits_in    = '0;
         end else if (lead_pending_ff) begin
            q_push          = 1'b1;
            q_entry.op      = OP_PAIR;
            q_entry.data    = {lead_bits_ff, req_in_byte[5:0]};
            lead_pending_in = 1'b0;
            lead_bits_in    = '0;
         end else if (!req_in_byte[7]) begin
            q_push          = 1'b1;
         end else if (!req_in_byte[5]) begin
            // two-byte lead: wait for the follower
            lead_pending_in = 1'b1;
            lead_bits_in    = req_in_byte[LeadW-1:0];
         end else begin
            q_push          = 1'b1;
            q_entry.op      = OP_FAIL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_pending_ff <= 1'b0;
         lead_bits_ff    <= '0;
      end else begin
         lead_pending_ff <= lead_pending_in;
         lead_bits_ff    <= lead_bits_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/ucp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module ucp_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  ucp_pkg::entry_type  push_entry,
   output logic                full,
   output logic                head_valid,
   output ucp_pkg::entry_type  head_entry,
   input  wire                 pop
);
   import ucp_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full       = count_ff[1];
   assign head_valid = count_ff != 2'd0;
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

FILE: sv/ucp_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ucp_back (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         q_valid,
   input  ucp_pkg::entry_type          q_entry,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic [ucp_pkg::ByteW-1:0]   rsp_out_byte,
   output logic [ucp_pkg::KindW-1:0]   rsp_out_kind
);
   import ucp_pkg::*;

   logic             failed_ff, failed_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ByteW-1:0] byte_ff, byte_in;
   logic [KindW-1:0] kind_ff, kind_in;
   logic             advance;
   logic             emit;
   map_type          mapped;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign q_pop   = q_valid && advance;
   assign mapped  = map_code(q_entry.data);

   always_comb begin
      failed_in = failed_ff;
      emit      = 1'b0;
      byte_in   = byte_ff;
      kind_in   = kind_ff;
      if (q_pop) begin
         unique case (q_entry.op)
            OP_END: begin
               emit      = 1'b1;
               byte_in   = '0;
               kind_in   = (failed_ff || q_entry.data[0]) ? KIND_END_FAIL : KIND_END_OK;
               failed_in = 1'b0;
            end
            OP_CHAR: begin
               emit    = !failed_ff;
               byte_in = q_entry.data[ByteW-1:0];
               kind_in = KIND_CHAR;
            end
            OP_PAIR: begin
               // unmapped code point poisons the rest of the string
               if (!failed_ff) begin
                  emit      = mapped.hit;
                  failed_in = !mapped.hit;
               end
               byte_in = mapped.code;
               kind_in = KIND_CHAR;
            end
            OP_FAIL: begin
               failed_in = 1'b1;
            end
            default: begin
               failed_in = 1'b1;
            end
         endcase
      end
      rsp_valid_in = advance ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_in;
         kind_ff <= kind_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_kind = kind_ff;

endmodule
`default_nettype wire

FILE: sv/utf8_to_cp1251_decoder.sv
// UTF-8 to Windows-1251 transcoder.
// req channel: one UTF-8 byte per transaction on req_in_byte; a zero byte ends
// the string. rsp channel: one Windows-1251 byte per transaction on
// rsp_out_byte with rsp_out_kind 0, or the end report (byte 0, kind 1 for a
// clean string, kind 2 for a failed one). Lead bytes, three-byte leads,
// unmapped code points and later nonzero bytes of a failed string give none.
// Throughput: one byte per cycle, sustained with both sides always ready.
// Path: the front classifier is combinational and writes the two-entry queue on
// the accepting edge; the mapper loads the queue head into its output register,
// which holds the result, whenever that register is empty or being taken.
// A stalled rsp side holds the output register; the queue absorbs up to two
// more classified bytes before req_ready drops.
// Reset (synchronous) empties the queue and output register and clears the
// pending-lead and failure state; the block is ready the cycle after.
`timescale 1ns / 1ps
`default_nettype none
module utf8_to_cp1251_decoder (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire  [ucp_pkg::ByteW-1:0]   req_in_byte,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic [ucp_pkg::ByteW-1:0]   rsp_out_byte,
   output logic [ucp_pkg::KindW-1:0]   rsp_out_kind
);
   import ucp_pkg::*;

   logic      q_full;
   logic      q_push;
   entry_type q_push_entry;
   logic      q_valid;
   entry_type q_head;
   logic      q_pop;

   ucp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_push_entry)
   );

   ucp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .head_valid (q_valid),
      .head_entry (q_head),
      .pop        (q_pop)
   );

   ucp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_entry      (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_kind (rsp_out_kind)
   );

endmodule
`default_nettype wire

FILE: sv/ucp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ucp_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         req_valid,
   input wire                         req_ready,
   input wire [ucp_pkg::ByteW-1:0]    req_in_byte,
   input wire                         rsp_valid,
   input wire                         rsp_ready,
   input wire [ucp_pkg::ByteW-1:0]    rsp_out_byte,
   input wire [ucp_pkg::KindW-1:0]    rsp_out_kind
);
   import ucp_pkg::*;

   // nothing left over from before reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_kind))
      else $error("stalled rsp transaction changed");

   // end reports carry a zero byte
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_kind == KIND_END_OK || rsp_out_kind == KIND_END_FAIL)
         |-> rsp_out_byte == '0)
      else $error("end report with nonzero byte");

   // characters are never zero and kind is always a known code
   a_char_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_kind == KIND_CHAR && rsp_out_byte != '0)
         || rsp_out_kind == KIND_END_OK || rsp_out_kind == KIND_END_FAIL)
      else $error("bad character or kind on rsp");

   // a terminator on an idle block is always reported
   a_req_seen: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_in_byte == '0 && !rsp_valid |=> 1'b1 ##1 rsp_valid)
      else $error("terminator not reported");

endmodule

bind utf8_to_cp1251_decoder ucp_checker u_ucp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_in_byte  (req_in_byte),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_kind (rsp_out_kind)
);
`default_nettype wire

FILE: bench/utf8_to_cp1251_decoder_test.sv
`timescale 1ns / 1ps
module utf8_to_cp1251_decoder_test;
   import ucp_pkg::*;

   localparam int WatchdogLimit = 1000;
   localparam int HoldCycles    = 60;
   localparam int DrainCycles   = 8;
   localparam int DirectedCount = 24;

   typedef struct packed {
      logic [ByteW-1:0] data;
      logic [KindW-1:0] kind;
   } cp1251_result_type;

   typedef struct packed {
      logic [ByteW-1:0]  in_byte;
      logic              typed;
      cp1251_result_type want;
   } directed_row_type;

   typedef struct packed {
      logic             hit;
      logic [ByteW-1:0] code;
   } lookup_type;

   // typed rows carry their result, the rest go through the predictor
   localparam directed_row_type DirectedRows [DirectedCount] = '{
      '{8'h00, 1'b1, '{8'h00, KIND_END_OK}},   // empty string right after reset
      '{8'h7F, 1'b1, '{8'h7F, KIND_CHAR}},     // highest ascii
      '{8'h01, 1'b1, '{8'h01, KIND_CHAR}},     // lowest ascii
      '{8'hD0, 1'b0, '0},                      // lowest cyrillic letter
      '{8'h90, 1'b0, '0},
      '{8'hD1, 1'b0, '0},                      // highest cyrillic letter
      '{8'h8F, 1'b0, '0},
      '{8'hC2, 1'b0, '0},                      // latin-1 pass through
      '{8'h80, 1'b0, '0},
      '{8'hD0, 1'b0, '0},                      // dje offset range
      '{8'h82, 1'b0, '0},
      '{8'hD2, 1'b0, '0},                      // reverse table hit
      '{8'h91, 1'b0, '0},
      '{8'h00, 1'b1, '{8'h00, KIND_END_OK}},
      '{8'h80, 1'b0, '0},                      // bare continuation taken as lead
      '{8'h41, 1'b0, '0},                      // overlong code point, unmapped
      '{8'h41, 1'b0, '0},                      // dropped after the failure
      '{8'h00, 1'b1, '{8'h00, KIND_END_FAIL}},
      '{8'hE0, 1'b0, '0},                      // three-byte lead
      '{8'h00, 1'b1, '{8'h00, KIND_END_FAIL}},
      '{8'hDF, 1'b0, '0},                      // lead cut off by the terminator
      '{8'h00, 1'b1, '{8'h00, KIND_END_FAIL}},
      '{8'hFF, 1'b0, '0},                      // top byte value
      '{8'h00, 1'b1, '{8'h00, KIND_END_FAIL}}
   };

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [ByteW-1:0] req_in_byte;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [ByteW-1:0] rsp_out_byte;
   logic [KindW-1:0] rsp_out_kind;

   utf8_to_cp1251_decoder dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_kind (rsp_out_kind)
   );

   cp1251_result_type expected_cp1251 [$];

   // transcoder state as the predictor sees it
   logic             lead_open;
   logic [LeadW-1:0] lead_hi;
   logic             string_bad;

   int send_idle_pct;
   int recv_idle_pct;
   bit hold_pending;
   bit hold_done;
   int mismatch_count;
   int bytes_sent;
   int chars_checked;
   int ends_ok;
   int ends_failed;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic lookup_type cp1251_lookup(input logic [CodeW-1:0] cp);
      logic [CodeW-1:0] diff;
      lookup_type       res;
      res.hit  = 1'b1;
      res.code = '0;
      if (cp >= 11'h410 && cp <= 11'h44F) begin
         diff     = cp - 11'h350;
         res.code = diff[ByteW-1:0];
      end else if (cp >= 11'h080 && cp <= 11'h0FF) begin
         res.code = cp[ByteW-1:0];
      end else if (cp == 11'h402 || cp == 11'h403) begin
         diff     = cp - 11'h382;
         res.code = diff[ByteW-1:0];
      end else begin
         // only the cyrillic extras fit in 11 bits, latin ones map to themselves
         case (cp)
            11'h401: res.code = 8'hA8;   11'h404: res.code = 8'hAA;
            11'h405: res.code = 8'hBD;   11'h406: res.code = 8'hB2;
            11'h407: res.code = 8'hAF;   11'h408: res.code = 8'hA3;
            11'h409: res.code = 8'h8A;   11'h40A: res.code = 8'h8C;
            11'h40B: res.code = 8'h8E;   11'h40C: res.code = 8'h8D;
            11'h40E: res.code = 8'hA1;   11'h40F: res.code = 8'h8F;
            11'h451: res.code = 8'hB8;   11'h452: res.code = 8'h90;
            11'h453: res.code = 8'h83;   11'h454: res.code = 8'hBA;
            11'h455: res.code = 8'hBE;   11'h456: res.code = 8'hB3;
            11'h457: res.code = 8'hBF;   11'h458: res.code = 8'hBC;
            11'h459: res.code = 8'h9A;   11'h45A: res.code = 8'h9C;
            11'h45B: res.code = 8'h9E;   11'h45C: res.code = 8'h9D;
            11'h45E: res.code = 8'hA2;   11'h45F: res.code = 8'h9F;
            11'h490: res.code = 8'hA5;   11'h491: res.code = 8'hB4;
            default: res.hit = 1'b0;
         endcase
      end
      return res;
   endfunction

   task automatic transcode_byte(input logic [ByteW-1:0] b, output bit emits,
                                 output cp1251_result_type r);
      lookup_type found;
      emits = 1'b0;
      r     = '0;
      if (b == '0) begin
         emits      = 1'b1;
         r.kind     = (string_bad || lead_open) ? KIND_END_FAIL : KIND_END_OK;
         lead_open  = 1'b0;
         lead_hi    = '0;
         string_bad = 1'b0;
      end else if (string_bad) begin
         // everything up to the terminator is dropped
      end else if (lead_open) begin
         found     = cp1251_lookup({lead_hi, b[5:0]});
         lead_open = 1'b0;
         lead_hi   = '0;
         if (found.hit) begin
            emits  = 1'b1;
            r.data = found.code;
            r.kind = KIND_CHAR;
         end else begin
            string_bad = 1'b1;
         end
      end else if (!b[7]) begin
         emits  = 1'b1;
         r.data = b;
         r.kind = KIND_CHAR;
      end else if (!b[5]) begin
         lead_open = 1'b1;
         lead_hi   = b[LeadW-1:0];
      end else begin
         string_bad = 1'b1;
      end
   endtask

   // entered and left at a falling edge
   task automatic send_byte(input logic [ByteW-1:0] b, input logic typed = 1'b0,
                            input cp1251_result_type want = '0);
      bit                emits;
      cp1251_result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      transcode_byte(b, emits, predicted);
      if (typed)
         expected_cp1251.push_back(want);
      else if (emits)
         expected_cp1251.push_back(predicted);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_string();
      int               n;
      int               pick;
      logic [CodeW-1:0] cp;
      logic [ByteW-1:0] tail;
      n = $urandom_range(0, 14);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            send_byte(8'($urandom_range(1, 127)));
         end else if (pick < 85) begin
            case ($urandom_range(0, 4))
               0:       cp = 11'(11'h410 + $urandom_range(0, 63));
               1:       cp = 11'(11'h080 + $urandom_range(0, 127));
               2:       cp = 11'(11'h402 + $urandom_range(0, 1));
               3:       cp = 11'(11'h400 + $urandom_range(0, 159));
               default: cp = 11'($urandom_range(0, 2047));
            endcase
            // bit 6 of the lead and the top bits of the tail are not checked
            tail = {2'b10, cp[5:0]};
            if ($urandom_range(0, 7) == 0)
               tail[7:6] = 2'($urandom());
            if (tail == '0)
               tail = 8'h80;
            send_byte({1'b1, 1'($urandom_range(0, 7) != 0), 1'b0, cp[10:6]});
            send_byte(tail);
         end else if (pick < 93) begin
            send_byte(8'($urandom_range(1, 255)));
         end else if (pick < 97) begin
            send_byte({1'b1, 1'($urandom()), 1'b1, 5'($urandom())});
         end else begin
            send_byte({3'b110, 5'($urandom())});
            break;
         end
      end
      send_byte(8'h00);
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int items,
                            input bit with_hold);
      int first;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      first         = bytes_sent;
      while (bytes_sent - first < items) begin
         if (with_hold && !hold_done && bytes_sent - first > items / 3) begin
            hold_pending = 1'b1;
            hold_done    = 1'b1;
         end
         send_random_string();
      end
   endtask

   // sender stays quiet until every result is back
   task automatic await_all_results();
      req_valid <= 1'b0;
      while (expected_cp1251.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off counted here
   initial begin
      int hold_left;
      bit idle_now;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HoldCycles;
         end
         idle_now = ($urandom_range(0, 99) < recv_idle_pct);
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !idle_now;
         end
      end
   end

   always @(posedge clock) begin
      cp1251_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cp1251.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction byte %h kind %0d",
                                      rsp_out_byte, rsp_out_kind));
         end else begin
            want = expected_cp1251.pop_front();
            if (rsp_out_byte !== want.data)
               report_mismatch($sformatf("byte %h, wanted %h", rsp_out_byte, want.data));
            if (rsp_out_kind !== want.kind)
               report_mismatch($sformatf("kind %0d, wanted %0d", rsp_out_kind, want.kind));
            case (want.kind)
               KIND_CHAR:   chars_checked++;
               KIND_END_OK: ends_ok++;
               default:     ends_failed++;
            endcase
         end
      end
   end

   initial begin
      int stall;
      stall = 0;
      while (stall < WatchdogLimit) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall = 0;
         else
            stall++;
      end
      $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_in_byte   = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_pending  = 1'b0;
      hold_done     = 1'b0;
      lead_open     = 1'b0;
      lead_hi       = '0;
      string_bad    = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 33;
      recv_idle_pct = 55;
      for (int i = 0; i < DirectedCount; i++)
         send_byte(DirectedRows[i].in_byte, DirectedRows[i].typed, DirectedRows[i].want);
      await_all_results();

      run_phase(33, 55, 600, 1'b0);
      await_all_results();
      run_phase(55, 33, 600, 1'b0);
      await_all_results();
      run_phase(0, 0, 700, 1'b1);
      req_valid <= 1'b0;

      for (int i = 0; i < 200 && expected_cp1251.size() != 0; i++) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (expected_cp1251.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_cp1251.size()));

      $display("covered %0d input bytes: %0d characters, %0d clean and %0d failed strings",
               bytes_sent, chars_checked, ends_ok, ends_failed);
      $display("under three idle mixes and one long output stall, %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: utf8_to_cp1251_decoder.f
sv/ucp_pkg.sv
sv/ucp_front.sv
sv/ucp_queue.sv
sv/ucp_back.sv
sv/utf8_to_cp1251_decoder.sv
sv/ucp_checker.sv
bench/utf8_to_cp1251_decoder_test.sv
